// ----- rtl/bilf_pkg.sv -----
// bilf_pkg: shared types and constants of the binary 3x3 lookup image filter
// no dependencies
package bilf_pkg;

	localparam int MAX_SIDE_DEF = 256;
	localparam int NUM_TABLE_REGS = 8;
	localparam int TABLE_REG_W = 64;
	localparam int CFG_IDX_W = 4;
	localparam int TABLE_IDX_W = 9;
	localparam int PASS_W = 6;
	localparam int COUNT_W = 17;
	localparam logic [TABLE_IDX_W-1:0] FULL_INDEX = 9'h1FF;
	localparam logic [TABLE_IDX_W-1:0] EMPTY_INDEX = 9'h000;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_PCHECK,
		ST_PASS,
		ST_PEND,
		ST_COUNT,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       init;
		logic       shift;
		logic       capture;
		logic [1:0] row;
	} win_ctl_t;

endpackage

// ----- rtl/bilf_ram.sv -----
// bilf_ram: generic memory, WIDTH bits wide (one bit by default), one write port, one registered read port
// no dependencies
module bilf_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/bilf_lut.sv -----
// bilf_lut: 512-entry lookup table registers with the configuration write port
// depends on bilf_pkg
module bilf_lut (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bilf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bilf_pkg::TABLE_REG_W-1:0]     cfg_data,
	input  logic [bilf_pkg::TABLE_IDX_W-1:0]     idx,
	output logic                                 lut_bit,
	output logic                                 lut_empty,
	output logic                                 lut_full
);
	import bilf_pkg::*;

	logic [NUM_TABLE_REGS-1:0][TABLE_REG_W-1:0] table_q;
	logic [NUM_TABLE_REGS*TABLE_REG_W-1:0]      flat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_q <= '0;
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_TABLE_REGS))) begin
			table_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	assign flat      = table_q;
	assign lut_bit   = flat[idx];
	assign lut_empty = flat[EMPTY_INDEX];
	assign lut_full  = flat[FULL_INDEX];

endmodule

// ----- rtl/bilf_window.sv -----
// bilf_window: 3x3 neighborhood window, filled one column pixel at a time
// depends on bilf_pkg
module bilf_window (
	input  logic                                 clk,
	input  bilf_pkg::win_ctl_t                   ctl,
	input  logic                                 bg,
	input  logic                                 cap_val,
	output logic [bilf_pkg::TABLE_IDX_W-1:0]     idx
);
	import bilf_pkg::*;

	logic [2:0][2:0] win_q;

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= bg;
				win_q[i][1] <= bg;
			end
		end else if (ctl.shift) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
		end
		if (ctl.capture) begin
			win_q[ctl.row][2] <= cap_val;
		end
	end

	// bottom-right pixel comes straight from the read
	assign idx = {win_q[0][0], win_q[0][1], win_q[0][2],
		win_q[1][0], win_q[1][1], win_q[1][2],
		win_q[2][0], win_q[2][1], cap_val};

endmodule

// ----- rtl/binary_3x3_lookup_image_filter.sv -----
// binary_3x3_lookup_image_filter: top level, sequencer and image state
// depends on bilf_pkg, bilf_ram, bilf_lut, bilf_window
//
// usage: a word is taken at a clock edge with start high and busy low.
// operation load stores one pixel of the image, row by row; row_end closes a
// row and the first row sets the width. a row that ends short of the width
// then holds busy while the missing columns are written unlit.
// operation run applies up to pass_count passes, then gives one result word:
// done is high for exactly one cycle with lit_count, background_lit and
// overflow. passes stop, with overflow set, once the grown image would exceed
// MAX_SIDE. each pass visits every pixel of the grown image with three pixel
// memory reads into the shared window and then one lookup and write.
// the count reads the final image once, and done follows the last read
// through ST_DRAIN; with a lit background or an empty image the count is
// skipped and done follows the final check. busy is high for the run.
// configuration writes on cfg_we/cfg_index/cfg_data load the table; they are
// taken in any cycle and should come only while the block is idle.
// reset clears the table, the image size and the background; pixel memory
// holds no reset value. the receiver cannot stall: done is never held.
module binary_3x3_lookup_image_filter #(
	parameter int MAX_SIDE = bilf_pkg::MAX_SIDE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               operation,
	input  logic                               pixel,
	input  logic                               row_end,
	input  logic [bilf_pkg::PASS_W-1:0]        pass_count,
	output logic                               done,
	output logic [bilf_pkg::COUNT_W-1:0]       lit_count,
	output logic                               background_lit,
	output logic                               overflow,
	input  logic                               cfg_we,
	input  logic [bilf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bilf_pkg::TABLE_REG_W-1:0]   cfg_data
);
	import bilf_pkg::*;

	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int CW     = $clog2(MAX_SIDE);
	localparam int AW     = 2 * CW + 1;
	localparam int DEPTH  = 1 << AW;
	localparam logic [SIDE_W:0] MAX_X = (SIDE_W+1)'(MAX_SIDE);

	state_t state_q, state_d;

	logic [SIDE_W-1:0] width_q, height_q, col_q;
	logic [SIDE_W-1:0] fill_col_q, fill_row_q;
	logic [SIDE_W-1:0] r_q, c_q;
	logic [1:0]        k_q;
	logic              bg_q, plane_q, fresh_q, ovf_q;
	logic [PASS_W-1:0] passes_q;
	logic [COUNT_W-1:0] cnt_q;
	logic              oob_s1, rd_vld_s1;

	logic              accept, ld_acc, run_acc;
	logic [SIDE_W-1:0] h_e, w_e, c_e;
	logic [SIDE_W:0]   c_inc, nw, nh, rr_sum, h_grow, w_grow;
	logic              store_ok;

	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic              wdata, rdata;
	logic              cap_val, lut_bit, lut_empty, lut_full;
	logic [TABLE_IDX_W-1:0] idx;
	win_ctl_t          wctl;
	logic              row_oob;
	logic [SIDE_W:0]   rr;
	logic              last_c_pass, last_r_pass, last_c_cnt, last_r_cnt;
	logic              grow_ovf, skip_count;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign ld_acc  = accept && (operation == OP_LOAD);
	assign run_acc = accept && (operation == OP_RUN);

	// effective image state for a load, a new image starts cleared
	assign h_e   = fresh_q ? '0 : height_q;
	assign w_e   = fresh_q ? '0 : width_q;
	assign c_e   = fresh_q ? '0 : col_q;
	assign c_inc = {1'b0, c_e} + 1'b1;
	assign store_ok = ({1'b0, h_e} < MAX_X) && ({1'b0, c_e} < MAX_X) &&
		((h_e == '0) || (c_e < w_e));

	assign nh     = {1'b0, height_q} + (SIDE_W+1)'(2);
	assign nw     = {1'b0, width_q} + (SIDE_W+1)'(2);
	assign h_grow = nh;
	assign w_grow = nw;
	assign grow_ovf   = (w_grow > MAX_X) || (h_grow > MAX_X);
	assign skip_count = bg_q || (height_q == '0) || (width_q == '0);

	assign rr_sum  = {1'b0, r_q} + {{(SIDE_W-1){1'b0}}, k_q};
	assign rr      = rr_sum - (SIDE_W+1)'(2);
	assign row_oob = (rr_sum < (SIDE_W+1)'(2)) || (rr_sum >= nh) || (c_q >= width_q);

	assign last_c_pass = ({1'b0, c_q} + 1'b1) == nw;
	assign last_r_pass = ({1'b0, r_q} + 1'b1) == nh;
	assign last_c_cnt  = ({1'b0, c_q} + 1'b1) == {1'b0, width_q};
	assign last_r_cnt  = ({1'b0, r_q} + 1'b1) == {1'b0, height_q};

	assign cap_val = oob_s1 ? bg_q : rdata;

	// write and read port selection
	always_comb begin
		we    = 1'b0;
		wdata = 1'b0;
		waddr = {plane_q, r_q[CW-1:0], c_q[CW-1:0]};
		raddr = {plane_q, r_q[CW-1:0], c_q[CW-1:0]};
		wctl  = '0;
		unique case (state_q)
			ST_IDLE: begin
				we    = ld_acc && store_ok;
				wdata = pixel;
				waddr = {plane_q, h_e[CW-1:0], c_e[CW-1:0]};
			end
			ST_FILL: begin
				we    = 1'b1;
				waddr = {plane_q, fill_row_q[CW-1:0], fill_col_q[CW-1:0]};
			end
			ST_PASS: begin
				raddr     = {plane_q, rr[CW-1:0], c_q[CW-1:0]};
				wctl.init  = (k_q == 2'd0) && (c_q == '0);
				wctl.shift = (k_q == 2'd0) && (c_q != '0);
				wctl.capture = (k_q != 2'd0);
				wctl.row   = k_q - 2'd1;
				we    = (k_q == 2'd3);
				wdata = lut_bit;
				waddr = {~plane_q, r_q[CW-1:0], c_q[CW-1:0]};
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (run_acc) begin
					state_d = ST_PCHECK;
				end else if (ld_acc && row_end && (h_e != '0) &&
						({1'b0, h_e} < MAX_X) && (c_inc < {1'b0, w_e})) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (({1'b0, fill_col_q} + 1'b1) >= {1'b0, width_q}) begin
					state_d = ST_IDLE;
				end
			end
			ST_PCHECK: begin
				if ((passes_q != '0) && !grow_ovf) begin
					state_d = ST_PASS;
				end else if (skip_count) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_COUNT;
				end
			end
			ST_PASS: begin
				if ((k_q == 2'd3) && last_c_pass && last_r_pass) begin
					state_d = ST_PEND;
				end
			end
			ST_PEND: state_d = ST_PCHECK;
			ST_COUNT: begin
				if (last_c_cnt && last_r_cnt) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= '0;
			height_q   <= '0;
			col_q      <= '0;
			bg_q       <= 1'b0;
			plane_q    <= 1'b0;
			fresh_q    <= 1'b1;
			ovf_q      <= 1'b0;
			passes_q   <= '0;
			fill_col_q <= '0;
			fill_row_q <= '0;
			r_q        <= '0;
			c_q        <= '0;
			k_q        <= '0;
			cnt_q      <= '0;
			oob_s1     <= 1'b0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_COUNT);
			if (rd_vld_s1) begin
				cnt_q <= cnt_q + {{(COUNT_W-1){1'b0}}, rdata};
			end
			unique case (state_q)
				ST_IDLE: begin
					if (ld_acc) begin
						fresh_q  <= 1'b0;
						if (fresh_q) begin
							bg_q <= 1'b0;
						end
						if (row_end && (h_e == '0)) begin
							width_q <= (c_inc > MAX_X) ? MAX_X[SIDE_W-1:0]
								: c_inc[SIDE_W-1:0];
						end else begin
							width_q <= w_e;
						end
						if (row_end && ({1'b0, h_e} < MAX_X)) begin
							height_q <= h_e + 1'b1;
						end else begin
							height_q <= h_e;
						end
						if (row_end) begin
							fill_col_q <= c_inc[SIDE_W-1:0];
							fill_row_q <= h_e;
							col_q      <= '0;
						end else begin
							col_q <= ({1'b0, c_e} < MAX_X) ? c_inc[SIDE_W-1:0]
								: MAX_X[SIDE_W-1:0];
						end
					end else if (run_acc) begin
						col_q    <= '0;
						ovf_q    <= 1'b0;
						passes_q <= pass_count;
					end
				end
				ST_FILL: begin
					fill_col_q <= fill_col_q + 1'b1;
				end
				ST_PCHECK: begin
					r_q   <= '0;
					c_q   <= '0;
					k_q   <= '0;
					cnt_q <= '0;
					if ((passes_q != '0) && grow_ovf) begin
						ovf_q <= 1'b1;
					end
				end
				ST_PASS: begin
					oob_s1 <= row_oob;
					k_q    <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						if (last_c_pass) begin
							c_q <= '0;
							r_q <= r_q + 1'b1;
						end else begin
							c_q <= c_q + 1'b1;
						end
					end
				end
				ST_PEND: begin
					bg_q     <= bg_q ? lut_full : lut_empty;
					height_q <= h_grow[SIDE_W-1:0];
					width_q  <= w_grow[SIDE_W-1:0];
					plane_q  <= ~plane_q;
					passes_q <= passes_q - 1'b1;
				end
				ST_COUNT: begin
					if (last_c_cnt) begin
						c_q <= '0;
						r_q <= r_q + 1'b1;
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				ST_DONE: begin
					fresh_q <= 1'b1;
					col_q   <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	bilf_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	bilf_lut u_lut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.idx       (idx),
		.lut_bit   (lut_bit),
		.lut_empty (lut_empty),
		.lut_full  (lut_full)
	);

	bilf_window u_win (
		.clk     (clk),
		.ctl     (wctl),
		.bg      (bg_q),
		.cap_val (cap_val),
		.idx     (idx)
	);

	assign done           = (state_q == ST_DONE);
	assign lit_count      = bg_q ? '0 : cnt_q;
	assign background_lit = bg_q;
	assign overflow       = ovf_q;

endmodule
